FILE: rtl/core/szcr_pkg.sv
// szcr_pkg: shared types and constants of the sliding zero-crossing rate core
// no dependencies; used by every module under rtl/core
package szcr_pkg;

  // configuration register layout
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned WinSizeW   = 11;
  localparam int unsigned HopW       = 16;
  localparam logic [CfgIdxW-1:0] CfgWindowSize = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHopSize    = 2'd1;
  localparam logic [WinSizeW-1:0] WinSizeReset = 11'd256;
  localparam logic [HopW-1:0]     HopReset     = 16'd128;

  // result field widths
  localparam int unsigned WinNumW  = 16;
  localparam int unsigned CountW   = 10;
  localparam int unsigned RateW    = 17;
  localparam int unsigned DivStepW = $clog2(RateW);

  // depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // one classified request handed from front to back
  typedef struct packed {
    logic restart;
    logic flag;
  } item_t;

endpackage

FILE: rtl/core/szcr_front.sv
// szcr_front: accepts samples and classifies them as frame restart or neighbour pair
// depends on szcr_pkg
module szcr_front #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_restart_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          first_of_frame_i,
  output logic                          push_o,
  output szcr_pkg::item_t               item_o,
  input  logic                          full_i
);

  logic prev_nonneg_q, prev_nonneg_d;
  logic in_frame_q, in_frame_d;
  logic nonneg;
  logic accept;

  // classification of the incoming sample
  assign nonneg         = ~sample_i[SAMPLE_BITS-1];
  assign in_stall_o     = full_i;
  assign accept         = in_valid_i & ~full_i;
  assign push_o         = accept;
  assign item_o.restart = first_of_frame_i | ~in_frame_q;
  assign item_o.flag    = prev_nonneg_q ^ nonneg;

  // sign history and frame tracking
  always_comb begin
    prev_nonneg_d = prev_nonneg_q;
    in_frame_d    = in_frame_q;
    if (cfg_restart_i) begin
      in_frame_d = 1'b0;
    end else if (accept) begin
      prev_nonneg_d = nonneg;
      in_frame_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_nonneg_q <= 1'b0;
      in_frame_q    <= 1'b0;
    end else begin
      prev_nonneg_q <= prev_nonneg_d;
      in_frame_q    <= in_frame_d;
    end
  end

endmodule

FILE: rtl/core/szcr_queue.sv
// szcr_queue: short fifo of classified requests between front and back
// depends on szcr_pkg
module szcr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  szcr_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output szcr_pkg::item_t item_o
);

  szcr_pkg::item_t                  mem_q [szcr_pkg::QueueDepth];
  logic [szcr_pkg::QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [szcr_pkg::QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [szcr_pkg::QueuePtrW:0]     fill_q, fill_d;
  logic                             do_push, do_pop;

  // status and read side
  assign full_o  = (fill_q == (szcr_pkg::QueuePtrW+1)'(szcr_pkg::QueueDepth));
  assign valid_o = (fill_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // pointer and fill update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (!do_push && do_pop) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/core/szcr_div.sv
// szcr_div: restoring divider, one quotient bit a cycle, for count*2^16/pairs
// depends on szcr_pkg
module szcr_div #(
  parameter int unsigned CNT_W = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [CNT_W-1:0]           num_i,
  input  logic [CNT_W-1:0]           den_i,
  output logic                       done_o,
  output logic [szcr_pkg::RateW-1:0] quot_o
);

  logic                                busy_q;
  logic                                first_q;
  logic                                done_q;
  logic [szcr_pkg::DivStepW-1:0]       step_q;
  logic [CNT_W-1:0]                    rem_q, rem_d;
  logic [szcr_pkg::RateW-1:0]          quot_q;
  logic [CNT_W:0]                      trial, diff;
  logic                                ge;

  // one trial subtraction; the first step takes the integer bit unshifted
  always_comb begin
    trial = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
    diff  = trial - {1'b0, den_i};
    ge    = (trial >= {1'b0, den_i});
    rem_d = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        first_q <= 1'b1;
        step_q  <= '0;
      end else if (busy_q) begin
        first_q <= 1'b0;
        step_q  <= step_q + 1'b1;
        if (step_q == szcr_pkg::DivStepW'(szcr_pkg::RateW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[szcr_pkg::RateW-2:0], ge};
    end
  end

endmodule

FILE: rtl/core/szcr_back.sv
// szcr_back: crossing flag ring, running count, window scheduling and result register
// depends on szcr_pkg and szcr_div
module szcr_back #(
  parameter int unsigned WINDOW_MAX = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [szcr_pkg::WinSizeW-1:0]   window_size_i,
  input  logic [szcr_pkg::HopW-1:0]       hop_size_i,
  input  logic                            item_valid_i,
  input  szcr_pkg::item_t                 item_i,
  output logic                            item_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [szcr_pkg::WinNumW-1:0]    window_number_o,
  output logic [szcr_pkg::CountW-1:0]     crossing_count_o,
  output logic [szcr_pkg::RateW-1:0]      crossing_rate_o
);

  localparam int unsigned CntW = $clog2(WINDOW_MAX);

  typedef enum logic [1:0] {
    StIdle,
    StUpdate,
    StDivide,
    StEmit
  } state_e;

  state_e                         state_q;
  logic [CntW-1:0]                ptr_q, ptr_eff_q;
  logic [CntW-1:0]                count_q, warm_q;
  logic [szcr_pkg::HopW-1:0]      hop_q;
  logic [szcr_pkg::WinNumW-1:0]   wcnt_q;
  logic                           flag_q;
  logic                           rd_q;
  logic                           ring_q [WINDOW_MAX];

  logic                           out_valid_q;
  logic [szcr_pkg::WinNumW-1:0]   res_wnum_q;
  logic [szcr_pkg::CountW-1:0]    res_count_q;
  logic [szcr_pkg::RateW-1:0]     res_rate_q;

  logic [31:0]                    ws_clamped;
  logic [CntW-1:0]                pairs;
  logic [szcr_pkg::HopW-1:0]      hop_reload;
  logic [CntW-1:0]                ptr_eff;
  logic [CntW-1:0]                ptr_next;
  logic [CntW-1:0]                count_d, warm_d;
  logic                           emit_now;
  logic                           ring_re, ring_we;
  logic                           div_done;
  logic [szcr_pkg::RateW-1:0]     div_quot;
  logic                           out_free;

  // pairs per window from the clamped window size, and the hop reload value
  always_comb begin
    ws_clamped = 32'(window_size_i);
    if (ws_clamped < 32'd2) begin
      ws_clamped = 32'd2;
    end else if (ws_clamped > 32'(WINDOW_MAX)) begin
      ws_clamped = 32'(WINDOW_MAX);
    end
    pairs      = CntW'(ws_clamped - 32'd1);
    hop_reload = (hop_size_i == '0) ? '0 : hop_size_i - 1'b1;
  end

  // ring pointer wraps when the window has shrunk under it
  assign ptr_eff = (ptr_q >= pairs) ? '0 : ptr_q;

  // running count update against the entry leaving the window
  always_comb begin
    if (warm_q < pairs) begin
      count_d = count_q + CntW'(flag_q);
      warm_d  = warm_q + 1'b1;
    end else begin
      count_d = count_q + CntW'(flag_q) - CntW'(rd_q);
      warm_d  = warm_q;
    end
    ptr_next = ((ptr_eff_q + 1'b1) == pairs) ? '0 : ptr_eff_q + 1'b1;
    emit_now = (warm_d >= pairs) && (hop_q == '0);
  end

  assign item_pop_o = (state_q == StIdle) && item_valid_i;
  assign ring_re    = item_pop_o && !item_i.restart;
  assign ring_we    = (state_q == StUpdate);
  assign out_free   = !out_valid_q || !out_stall_i;

  // flag ring memory
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[ptr_eff_q] <= flag_q;
    end
    if (ring_re) begin
      rd_q <= ring_q[ptr_eff];
    end
  end

  // rate divider
  szcr_div #(
    .CNT_W (CntW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i ((state_q == StUpdate) && emit_now),
    .num_i   (count_d),
    .den_i   (pairs),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // sequencer, analysis state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ptr_q       <= '0;
      ptr_eff_q   <= '0;
      count_q     <= '0;
      warm_q      <= '0;
      hop_q       <= '0;
      wcnt_q      <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      res_wnum_q  <= '0;
      res_count_q <= '0;
      res_rate_q  <= '0;
    end else begin
      // result valid: set on emit, cleared once taken
      if ((state_q == StEmit) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (item_valid_i) begin
            if (item_i.restart) begin
              ptr_q   <= '0;
              count_q <= '0;
              warm_q  <= '0;
              hop_q   <= '0;
              wcnt_q  <= '0;
            end else begin
              flag_q    <= item_i.flag;
              ptr_eff_q <= ptr_eff;
              state_q   <= StUpdate;
            end
          end
        end
        StUpdate: begin
          count_q <= count_d;
          warm_q  <= warm_d;
          ptr_q   <= ptr_next;
          state_q <= StIdle;
          if (warm_d >= pairs) begin
            if (hop_q != '0) begin
              hop_q <= hop_q - 1'b1;
            end else begin
              hop_q   <= hop_reload;
              state_q <= StDivide;
            end
          end
        end
        StDivide: begin
          if (div_done) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (out_free) begin
            res_wnum_q  <= wcnt_q;
            res_count_q <= szcr_pkg::CountW'(count_q);
            res_rate_q  <= div_quot;
            wcnt_q      <= wcnt_q + 1'b1;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign window_number_o  = res_wnum_q;
  assign crossing_count_o = res_count_q;
  assign crossing_rate_o  = res_rate_q;

endmodule

FILE: rtl/core/sliding_zero_crossing_rate_core.sv
// Sliding-window zero-crossing rate. Each sample's sign (zero counts as
// non-negative) is compared with the previous one; a ring of crossing flags
// keeps a running count over the last window_size-1 pairs, and every hop_size
// samples after the first full window a result gives the window number, the
// count and count/(window_size-1) as unsigned Q1.16, rounded down. The front
// takes one sample per cycle into a two-entry request queue while not full.
// The back handles a frame start in idle, a pair in idle (flag ring read)
// then in update (update and write on the single ring port), and a pair
// closing a window then in the 17-step quotient divider and the result
// register load, held while a result is stalled. A window-size or hop-size
// write restarts the analysis; the user makes writes only while the block is
// idle, unenforced by the block. The flag ring needs no clearing after reset.
// depends on szcr_pkg, szcr_front, szcr_queue, szcr_back
module sliding_zero_crossing_rate_core #(
  parameter int unsigned WINDOW_MAX  = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [szcr_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [szcr_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic                                first_of_frame_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [szcr_pkg::WinNumW-1:0]        window_number_o,
  output logic [szcr_pkg::CountW-1:0]         crossing_count_o,
  output logic [szcr_pkg::RateW-1:0]          crossing_rate_o
);

  logic [szcr_pkg::WinSizeW-1:0] window_size_q;
  logic [szcr_pkg::HopW-1:0]     hop_size_q;
  logic                          cfg_restart;
  logic                          push, full, pop, q_valid;
  szcr_pkg::item_t               push_item, pop_item;

  // configuration registers
  assign cfg_restart = cfg_we_i && ((cfg_index_i == szcr_pkg::CfgWindowSize) ||
                                    (cfg_index_i == szcr_pkg::CfgHopSize));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= szcr_pkg::WinSizeReset;
      hop_size_q    <= szcr_pkg::HopReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        szcr_pkg::CfgWindowSize: window_size_q <= cfg_data_i[szcr_pkg::WinSizeW-1:0];
        szcr_pkg::CfgHopSize:    hop_size_q    <= cfg_data_i[szcr_pkg::HopW-1:0];
        default: ;
      endcase
    end
  end

  // sample intake and classification
  szcr_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_restart_i    (cfg_restart),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .first_of_frame_i (first_of_frame_i),
    .push_o           (push),
    .item_o           (push_item),
    .full_i           (full)
  );

  // request queue
  szcr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  // window analysis and result
  szcr_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .window_size_i    (window_size_q),
    .hop_size_i       (hop_size_q),
    .item_valid_i     (q_valid),
    .item_i           (pop_item),
    .item_pop_o       (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .window_number_o  (window_number_o),
    .crossing_count_o (crossing_count_o),
    .crossing_rate_o  (crossing_rate_o)
  );

endmodule

FILE: verif/sliding_zero_crossing_rate_checker.sv
`timescale 1ns / 1ps
// sliding_zero_crossing_rate_checker: watches the request channels of the core, predicts each
// window result and compares it with what the core gives; depends on szcr_pkg only
module sliding_zero_crossing_rate_checker
  import szcr_pkg::*;
#(
  parameter int unsigned WINDOW_MAX  = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   first_of_frame_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [WinNumW-1:0]     window_number_i,
  input  logic [CountW-1:0]      crossing_count_i,
  input  logic [RateW-1:0]       crossing_rate_i,
  output int unsigned            errors_o,
  output int unsigned            outstanding_o
);

  typedef struct packed {
    logic [WinNumW-1:0] number;
    logic [CountW-1:0]  count;
    logic [RateW-1:0]   rate;
  } window_result_t;

  // predicted configuration
  logic [WinSizeW-1:0] win_reg;
  logic [HopW-1:0]     hop_reg;

  // predicted analysis state
  logic               framed;
  logic               prev_nonneg;
  logic               cross_ring [WINDOW_MAX];
  logic [9:0]         ring_ptr;
  logic [CountW-1:0]  run_count;
  logic [9:0]         pairs_seen;
  logic [HopW-1:0]    hop_left;
  logic [WinNumW-1:0] window_idx;

  window_result_t window_q [$];
  int unsigned    err_count = 0;
  int unsigned    reported  = 0;

  // start a fresh analysis at a frame boundary
  function automatic void restart_window();
    ring_ptr   = '0;
    run_count  = '0;
    pairs_seen = '0;
    hop_left   = '0;
    window_idx = '0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    window_result_t got;
    window_result_t want;
    logic           nonneg;
    logic           crossed;
    int unsigned    pairs;
    int unsigned    stride;
    int unsigned    slot;
    int unsigned    scaled;
    if (!rst_ni) begin
      win_reg     = WinSizeReset;
      hop_reg     = HopReset;
      framed      = 1'b0;
      prev_nonneg = 1'b0;
      restart_window();
      window_q.delete();
    end else begin
      // result side: compare with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        got.number = window_number_i;
        got.count  = crossing_count_i;
        got.rate   = crossing_rate_i;
        if (window_q.size() == 0) begin
          err_count++;
          if (reported < 10) begin
            $display("%0t: unexpected result: number %0d count %0d rate %0d",
                     $realtime, got.number, got.count, got.rate);
          end
          reported++;
        end else begin
          want = window_q.pop_front();
          if (got.number != want.number || got.count != want.count ||
              got.rate != want.rate) begin
            err_count++;
            if (reported < 10) begin
              $display("%0t: result mismatch: expected number %0d count %0d rate %0d,",
                       $realtime, want.number, want.count, want.rate);
              $display("    got number %0d count %0d rate %0d",
                       got.number, got.count, got.rate);
            end
            reported++;
          end
        end
      end

      // register writes restart the analysis; spare indexes are ignored
      if (cfg_we_i) begin
        if (cfg_index_i == CfgWindowSize) begin
          win_reg = cfg_data_i[WinSizeW-1:0];
          framed  = 1'b0;
        end else if (cfg_index_i == CfgHopSize) begin
          hop_reg = cfg_data_i[HopW-1:0];
          framed  = 1'b0;
        end
      end

      // sample request side
      if (in_valid_i && !in_stall_i) begin
        nonneg = ~sample_i[SAMPLE_BITS-1];
        if (win_reg < 2) pairs = 1;
        else if (win_reg > WINDOW_MAX) pairs = WINDOW_MAX - 1;
        else pairs = win_reg - 1;
        stride = (hop_reg == '0) ? 1 : hop_reg;
        if (first_of_frame_i || !framed) begin
          restart_window();
          framed      = 1'b1;
          prev_nonneg = nonneg;
        end else begin
          crossed     = prev_nonneg ^ nonneg;
          prev_nonneg = nonneg;
          slot = (ring_ptr >= pairs) ? 0 : ring_ptr;
          if (pairs_seen < pairs) begin
            run_count  = run_count + crossed;
            pairs_seen = pairs_seen + 1'b1;
          end else begin
            run_count = run_count + crossed - cross_ring[slot];
          end
          cross_ring[slot] = crossed;
          ring_ptr = (slot + 1 >= pairs) ? '0 : 10'(slot + 1);
          // a full window closes every stride samples
          if (pairs_seen >= pairs) begin
            if (hop_left != '0) begin
              hop_left = hop_left - 1'b1;
            end else begin
              hop_left    = HopW'(stride - 1);
              scaled      = run_count;
              want.number = window_idx;
              want.count  = run_count;
              want.rate   = RateW'((scaled << 16) / pairs);
              window_q.push_back(want);
              window_idx  = window_idx + 1'b1;
            end
          end
        end
      end
    end
    errors_o      <= err_count;
    outstanding_o <= window_q.size();
  end

endmodule

FILE: verif/sliding_zero_crossing_rate_core_tb.sv
`timescale 1ns / 1ps
// sliding_zero_crossing_rate_core_tb: clock, reset, sample and register stimulus, receiver stalls
// and the verdict; depends on szcr_pkg, the core and sliding_zero_crossing_rate_checker
module sliding_zero_crossing_rate_core_tb;
  import szcr_pkg::*;

  localparam int unsigned SampleW      = 16;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd2;
  localparam int unsigned RandomItems  = 300;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned CycleLimit   = 600000;

  logic                      clk_i            = 1'b0;
  logic                      rst_ni           = 1'b0;
  logic                      cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0]        cfg_index_i      = '0;
  logic [CfgDataW-1:0]       cfg_data_i       = '0;
  logic                      in_valid_i       = 1'b0;
  logic                      in_stall_o;
  logic signed [SampleW-1:0] sample_i         = '0;
  logic                      first_of_frame_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i      = 1'b0;
  logic [WinNumW-1:0]        window_number_o;
  logic [CountW-1:0]         crossing_count_o;
  logic [RateW-1:0]          crossing_rate_o;

  int unsigned errors;
  int unsigned outstanding;
  int unsigned sent          = 0;
  int unsigned snd_idle_pct  = 0;
  int unsigned rcv_stall_pct = 0;
  int unsigned hold_count    = 0;
  int unsigned cycle_count   = 0;
  logic        hold_go       = 1'b0;

  sliding_zero_crossing_rate_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .first_of_frame_i (first_of_frame_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .window_number_o  (window_number_o),
    .crossing_count_o (crossing_count_o),
    .crossing_rate_o  (crossing_rate_o)
  );

  sliding_zero_crossing_rate_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .sample_i         (sample_i),
    .first_of_frame_i (first_of_frame_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .window_number_i  (window_number_o),
    .crossing_count_i (crossing_count_o),
    .crossing_rate_i  (crossing_rate_o),
    .errors_o         (errors),
    .outstanding_o    (outstanding)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: one long hold-off on request, random stalls otherwise
  always @(posedge clk_i) begin
    if (hold_go && hold_count < HoldCycles) begin
      out_stall_i <= 1'b1;
      hold_count++;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rcv_stall_pct);
    end
  end

  // random sample of a given sign, extremes and zero included
  function automatic logic [SampleW-1:0] pick_sample(input logic neg);
    int unsigned r;
    r = $urandom_range(0, 15);
    if (neg) begin
      if (r == 0) return 16'h8000;
      if (r == 1) return 16'hFFFF;
      return {1'b1, 15'($urandom)};
    end
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'h7FFF;
    return {1'b0, 15'($urandom)};
  endfunction

  // drive one sample request, holding it until accepted
  task automatic send_sample(input logic [SampleW-1:0] value, input logic mark);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    sample_i         <= value;
    first_of_frame_i <= mark;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  // a frame whose sign flips with the given odds, with occasional stray frame marks
  task automatic send_frame(input int unsigned len, input int unsigned flip_pct,
                            input logic mark, input int unsigned stray_pct);
    logic neg;
    neg = 1'($urandom_range(0, 1));
    send_sample(pick_sample(neg), mark);
    for (int unsigned k = 1; k < len; k++) begin
      if ($urandom_range(0, 99) < flip_pct) neg = ~neg;
      send_sample(pick_sample(neg), ($urandom_range(0, 99) < stray_pct));
    end
  endtask

  // wait until every predicted result is out and the core has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [CfgDataW-1:0] win_data,
                           input logic [CfgDataW-1:0] hop_data);
    settle();
    write_reg(CfgWindowSize, win_data);
    write_reg(CfgHopSize, hop_data);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned      target;
    int unsigned      weff;
    int unsigned      stride;
    int unsigned      span;
    int unsigned      mode;
    logic [10:0]      win;
    logic [HopW-1:0]  hop;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // samples before any frame mark, under the reset settings
    send_sample(16'h0001, 1'b0);
    send_sample(16'h8000, 1'b0);

    // window below range clamps to two, hop of zero acts as one
    configure(16'h0001, 16'h0000);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);

    // a write to a spare index leaves the analysis running
    settle();
    write_reg(CfgSpare, 16'hFFFF);
    cfg_we_i <= 1'b0;
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);

    // three-sample windows every second sample
    configure(16'd3, 16'd2);
    send_sample(16'h0001, 1'b1);
    send_sample(16'hFFFE, 1'b0);
    send_sample(16'h0002, 1'b0);
    send_sample(16'hFFFD, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0003, 1'b0);
    send_sample(16'hC000, 1'b0);

    // long receiver hold-off with the sender pushing on
    configure(16'd2, 16'd1);
    hold_go <= 1'b1;
    send_frame(80, 50, 1'b1, 0);

    // random phases cycling through the idling modes
    target = sent + RandomItems;
    for (int unsigned ph = 0; sent < target; ph++) begin
      case ($urandom_range(0, 19))
        0:       win = 11'd0;
        1:       win = 11'd1;
        2, 3:    win = 11'd2;
        4:       win = 11'($urandom_range(13, 40));
        default: win = 11'($urandom_range(3, 12));
      endcase
      case ($urandom_range(0, 19))
        0:       hop = 16'd0;
        1:       hop = 16'hFFFF;
        2:       hop = 16'($urandom_range(7, 20));
        default: hop = 16'($urandom_range(1, 6));
      endcase
      weff   = (win < 2) ? 2 : win;
      stride = (hop == 0) ? 1 : hop;
      span   = (stride > 8) ? 8 : stride;
      configure({5'($urandom), win}, hop);
      mode = ph % 4;
      case (mode)
        0:       begin snd_idle_pct = 0;  rcv_stall_pct <= 0;  end
        1:       begin snd_idle_pct = 82; rcv_stall_pct <= 0;  end
        2:       begin snd_idle_pct = 0;  rcv_stall_pct <= 82; end
        default: begin snd_idle_pct = 20; rcv_stall_pct <= 20; end
      endcase
      // first frame may rely on the implicit restart after a write
      send_frame($urandom_range(1, weff + 4 * span + 2), $urandom_range(0, 100),
                 1'($urandom_range(0, 1)), 2);
      for (int unsigned f = 0; f < 3; f++) begin
        case ($urandom_range(0, 3))
          0:       send_frame($urandom_range(1, weff + 4 * span + 2), 0, 1'b1, 2);
          1:       send_frame($urandom_range(1, weff + 4 * span + 2), 100, 1'b1, 2);
          default: send_frame($urandom_range(1, weff + 4 * span + 2),
                              $urandom_range(0, 100), 1'b1, 2);
        endcase
      end
    end

    // largest window: oversize value clamps, alternating signs give full count
    configure(16'hFFFF, 16'h0000);
    snd_idle_pct = 0;
    rcv_stall_pct <= 50;
    send_frame(1027, 100, 1'b1, 0);

    settle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
